@@ sv/fcd_pkg.sv @@
// Shared types and constants for the follow command decider.
// Holds the command and register index codes, the register block struct and the decision struct.
// No dependencies.
`default_nettype none

package fcd_pkg;

    localparam int DATA_W = 16;
    localparam int TIME_W = 32;
    localparam int DIST_W = 15;
    localparam int HOLD_W = 16;
    localparam int ALPHA_W = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 17;
    localparam int FILTER_FRACTION_BITS_DEF = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA = ALPHA_W'(19661);
    localparam logic [DIST_W-1:0]  RST_STOP_DISTANCE = DIST_W'(480);
    localparam logic [DIST_W-1:0]  RST_MIN_DISTANCE = DIST_W'(800);
    localparam logic [DIST_W-1:0]  RST_TARGET_DISTANCE = DIST_W'(1600);
    localparam logic [DIST_W-1:0]  RST_DEAD_ZONE = DIST_W'(320);
    localparam logic [DIST_W-1:0]  RST_TURN_ON_ANGLE = DIST_W'(1280);
    localparam logic [DIST_W-1:0]  RST_TURN_OFF_ANGLE = DIST_W'(640);
    localparam logic [HOLD_W-1:0]  RST_HOLD_MS = HOLD_W'(300);

    typedef enum logic [1:0] {
        DRIVE_STOP  = 2'd0,
        DRIVE_FWD   = 2'd1,
        DRIVE_LEFT  = 2'd2,
        DRIVE_RIGHT = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FILTER_ALPHA    = 3'd0,
        CFG_STOP_DISTANCE   = 3'd1,
        CFG_MIN_DISTANCE    = 3'd2,
        CFG_TARGET_DISTANCE = 3'd3,
        CFG_DEAD_ZONE       = 3'd4,
        CFG_TURN_ON_ANGLE   = 3'd5,
        CFG_TURN_OFF_ANGLE  = 3'd6,
        CFG_HOLD_MS         = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] filter_alpha;
        logic [DIST_W-1:0]  stop_distance;
        logic [DIST_W-1:0]  min_distance;
        logic [DIST_W-1:0]  target_distance;
        logic [DIST_W-1:0]  dead_zone;
        logic [DIST_W-1:0]  turn_on_angle;
        logic [DIST_W-1:0]  turn_off_angle;
        logic [HOLD_W-1:0]  hold_ms;
    } cfg_t;

    // Decision handed from the decide logic to the state registers
    typedef struct packed {
        cmd_t cmd;
        logic set_time;
    } dec_t;

endpackage

`default_nettype wire

@@ sv/fcd_cfg_regs.sv @@
// Configuration register block of the follow command decider.
// Depends on fcd_pkg for the register struct, index codes and reset values.
`default_nettype none

module fcd_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [fcd_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [fcd_pkg::CFG_DATA_W-1:0]    wr_data,
    output fcd_pkg::cfg_t                          cfg
);
    import fcd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_alpha    <= RST_FILTER_ALPHA;
            cfg_reg.stop_distance   <= RST_STOP_DISTANCE;
            cfg_reg.min_distance    <= RST_MIN_DISTANCE;
            cfg_reg.target_distance <= RST_TARGET_DISTANCE;
            cfg_reg.dead_zone       <= RST_DEAD_ZONE;
            cfg_reg.turn_on_angle   <= RST_TURN_ON_ANGLE;
            cfg_reg.turn_off_angle  <= RST_TURN_OFF_ANGLE;
            cfg_reg.hold_ms         <= RST_HOLD_MS;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_FILTER_ALPHA:    cfg_reg.filter_alpha    <= wr_data[ALPHA_W-1:0];
                CFG_STOP_DISTANCE:   cfg_reg.stop_distance   <= wr_data[DIST_W-1:0];
                CFG_MIN_DISTANCE:    cfg_reg.min_distance    <= wr_data[DIST_W-1:0];
                CFG_TARGET_DISTANCE: cfg_reg.target_distance <= wr_data[DIST_W-1:0];
                CFG_DEAD_ZONE:       cfg_reg.dead_zone       <= wr_data[DIST_W-1:0];
                CFG_TURN_ON_ANGLE:   cfg_reg.turn_on_angle   <= wr_data[DIST_W-1:0];
                CFG_TURN_OFF_ANGLE:  cfg_reg.turn_off_angle  <= wr_data[DIST_W-1:0];
                CFG_HOLD_MS:         cfg_reg.hold_ms         <= wr_data[HOLD_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ sv/fcd_filter.sv @@
// One exponential low-pass filter step with seeding and alpha saturation.
// Depends on fcd_pkg for field widths and the alpha scale.
`default_nettype none

module fcd_filter #(
    parameter int FRAC_BITS = fcd_pkg::FILTER_FRACTION_BITS_DEF
) (
    input  wire logic signed [fcd_pkg::DATA_W+FRAC_BITS-1:0] f_cur,
    input  wire logic                                        seeded,
    input  wire logic signed [fcd_pkg::DATA_W-1:0]           sample,
    input  wire logic [fcd_pkg::ALPHA_W-1:0]                 alpha,
    output logic signed [fcd_pkg::DATA_W+FRAC_BITS-1:0]      f_next
);
    import fcd_pkg::*;

    localparam int FW = DATA_W + FRAC_BITS;
    localparam int DW = FW + 1;
    localparam int PW = DW + ALPHA_W + 1;
    localparam int SW = PW - ALPHA_FRAC;

    logic signed [FW-1:0]   x_scaled;
    logic signed [FW-1:0]   f_base;
    logic signed [DW-1:0]   diff;
    logic [ALPHA_W-1:0]     alpha_sat;
    logic signed [PW-1:0]   prod;
    logic signed [SW-1:0]   step;
    logic signed [SW-1:0]   sum;

    always_comb
    begin
        x_scaled  = {sample, {FRAC_BITS{1'b0}}};
        // first valid sample loads the filter, which makes the step zero
        f_base    = seeded ? f_cur : x_scaled;
        diff      = {x_scaled[FW-1], x_scaled} - {f_base[FW-1], f_base};
        alpha_sat = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        prod      = PW'(diff) * PW'($signed({1'b0, alpha_sat}));
        // arithmetic shift keeps the floor toward minus infinity
        step      = prod[PW-1:ALPHA_FRAC];
        sum       = {{(SW-FW){f_base[FW-1]}}, f_base} + step;
        f_next    = sum[FW-1:0];
    end

endmodule

`default_nettype wire

@@ sv/fcd_decide.sv @@
// Threshold, turn hysteresis and hold-time logic of the follow command decider.
// Depends on fcd_pkg for the command codes, register struct and decision struct.
`default_nettype none

module fcd_decide #(
    parameter int FRAC_BITS = fcd_pkg::FILTER_FRACTION_BITS_DEF
) (
    input  wire logic                                        sample_ok,
    input  wire logic signed [fcd_pkg::DATA_W+FRAC_BITS-1:0] f_dist,
    input  wire logic signed [fcd_pkg::DATA_W+FRAC_BITS-1:0] f_ang,
    input  fcd_pkg::cfg_t                                    cfg,
    input  fcd_pkg::cmd_t                                    prev_cmd,
    input  wire logic [fcd_pkg::TIME_W-1:0]                  now_ms,
    input  wire logic [fcd_pkg::TIME_W-1:0]                  change_time,
    output fcd_pkg::dec_t                                    dec
);
    import fcd_pkg::*;

    localparam int FW = DATA_W + FRAC_BITS;
    localparam int CW = FW + 2;
    localparam int TP = CW - DIST_W - FRAC_BITS;
    localparam int SP = CW - DIST_W - 1 - FRAC_BITS;

    logic signed [CW-1:0] d_ext;
    logic signed [CW-1:0] a_ext;
    logic signed [CW-1:0] a_abs;
    logic signed [CW-1:0] stop_th;
    logic signed [CW-1:0] min_th;
    logic signed [CW-1:0] fwd_th;
    logic signed [CW-1:0] on_th;
    logic signed [CW-1:0] off_th;
    logic [DIST_W:0]      fwd_sum;
    logic [TIME_W-1:0]    elapsed;
    logic                 too_close;
    logic                 turning;
    logic                 was_turning;
    logic                 hold;
    cmd_t                 raw_cmd;

    always_comb
    begin
        d_ext   = {{2{f_dist[FW-1]}}, f_dist};
        a_ext   = {{2{f_ang[FW-1]}}, f_ang};
        a_abs   = a_ext[CW-1] ? -a_ext : a_ext;
        stop_th = {{TP{1'b0}}, cfg.stop_distance, {FRAC_BITS{1'b0}}};
        min_th  = {{TP{1'b0}}, cfg.min_distance, {FRAC_BITS{1'b0}}};
        on_th   = {{TP{1'b0}}, cfg.turn_on_angle, {FRAC_BITS{1'b0}}};
        off_th  = {{TP{1'b0}}, cfg.turn_off_angle, {FRAC_BITS{1'b0}}};
        fwd_sum = {1'b0, cfg.target_distance} + {1'b0, cfg.dead_zone};
        fwd_th  = {{SP{1'b0}}, fwd_sum, {FRAC_BITS{1'b0}}};

        too_close   = (d_ext <= stop_th) || (d_ext < min_th);
        was_turning = (prev_cmd == DRIVE_LEFT) || (prev_cmd == DRIVE_RIGHT);
        turning     = was_turning ? (a_abs > off_th) : (a_abs > on_th);

        priority if (turning)
            raw_cmd = a_ext[CW-1] ? DRIVE_LEFT : DRIVE_RIGHT;
        else if (d_ext > fwd_th)
            raw_cmd = DRIVE_FWD;
        else
            raw_cmd = DRIVE_STOP;

        elapsed = now_ms - change_time;
        hold    = (raw_cmd != prev_cmd) && (prev_cmd != DRIVE_STOP)
                  && (elapsed < {{(TIME_W-HOLD_W){1'b0}}, cfg.hold_ms});

        // invalid sample and distance stop both bypass the hold
        priority if (!sample_ok || too_close)
        begin
            dec.cmd      = DRIVE_STOP;
            dec.set_time = 1'b0;
        end
        else
        begin
            dec.cmd      = hold ? prev_cmd : raw_cmd;
            dec.set_time = (dec.cmd != prev_cmd);
        end
    end

endmodule

`default_nettype wire

@@ sv/follow_command_decider_core.sv @@
// Top level of the follow command decider: input register, filters, decision, result register.
// Depends on fcd_pkg, fcd_cfg_regs, fcd_filter and fcd_decide.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one range sample per item:
//   distance, angle and now_ms. The output channel (out_valid/out_ready)
//   returns one item per sample: command, smoothed_distance, smoothed_angle.
//   The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one
//   register per item; cfg_ready is always high. Write it only while idle.
//   An accepted item sits in the input register, is decided and lands in
//   the result register once the result slot is free; out_valid then
//   rises. Throughput: one item per cycle while the result slot stays free;
//   the filter multiply, threshold compares and hold check are combinational
//   between the input register and the result register, and the filter,
//   command and change-time state update at the same edge.
//   Stall: while the result waits, one more item may sit in the input
//   register; then in_ready drops until out_ready takes the result.
//   Reset: registers return to their reset values, filters clear and are
//   unseeded, the last command is stop, the change time is zero.
`default_nettype none

module follow_command_decider_core #(
    parameter int FILTER_FRACTION_BITS = fcd_pkg::FILTER_FRACTION_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [fcd_pkg::DATA_W-1:0]   distance,
    input  wire logic signed [fcd_pkg::DATA_W-1:0]   angle,
    input  wire logic [fcd_pkg::TIME_W-1:0]          now_ms,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [1:0]                               command,
    output logic signed [fcd_pkg::DATA_W-1:0]        smoothed_distance,
    output logic signed [fcd_pkg::DATA_W-1:0]        smoothed_angle,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [fcd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fcd_pkg::*;

    localparam int FW = DATA_W + FILTER_FRACTION_BITS;

    cfg_t cfg;

    // input register
    logic                       in_vld_reg;
    logic signed [DATA_W-1:0]   dist_reg;
    logic signed [DATA_W-1:0]   ang_reg;
    logic [TIME_W-1:0]          now_reg;

    // decider state
    logic signed [FW-1:0]       dist_f_reg;
    logic signed [FW-1:0]       ang_f_reg;
    logic                       seeded_reg;
    cmd_t                       prev_cmd_reg;
    logic [TIME_W-1:0]          change_time_reg;

    // result register
    logic                       out_vld_reg;
    cmd_t                       cmd_reg;
    logic signed [DATA_W-1:0]   sm_dist_reg;
    logic signed [DATA_W-1:0]   sm_ang_reg;

    logic signed [FW-1:0]       dist_f_step;
    logic signed [FW-1:0]       ang_f_step;
    logic signed [FW-1:0]       dist_f_next;
    logic signed [FW-1:0]       ang_f_next;
    logic                       sample_ok;
    logic                       out_free;
    logic                       adv;
    dec_t                       dec;

    fcd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    fcd_filter #(.FRAC_BITS(FILTER_FRACTION_BITS)) u_dist_filter (
        .f_cur  (dist_f_reg),
        .seeded (seeded_reg),
        .sample (dist_reg),
        .alpha  (cfg.filter_alpha),
        .f_next (dist_f_step)
    );

    fcd_filter #(.FRAC_BITS(FILTER_FRACTION_BITS)) u_ang_filter (
        .f_cur  (ang_f_reg),
        .seeded (seeded_reg),
        .sample (ang_reg),
        .alpha  (cfg.filter_alpha),
        .f_next (ang_f_step)
    );

    // a distance of zero or less leaves the filters untouched
    assign sample_ok   = !dist_reg[DATA_W-1] && (dist_reg != '0);
    assign dist_f_next = sample_ok ? dist_f_step : dist_f_reg;
    assign ang_f_next  = sample_ok ? ang_f_step : ang_f_reg;

    fcd_decide #(.FRAC_BITS(FILTER_FRACTION_BITS)) u_decide (
        .sample_ok   (sample_ok),
        .f_dist      (dist_f_next),
        .f_ang       (ang_f_next),
        .cfg         (cfg),
        .prev_cmd    (prev_cmd_reg),
        .now_ms      (now_reg),
        .change_time (change_time_reg),
        .dec         (dec)
    );

    // advance the input register into the result register when the result slot frees up
    assign out_free  = !out_vld_reg || out_ready;
    assign adv       = in_vld_reg && out_free;
    assign in_ready  = !in_vld_reg || adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // hold the payload once captured
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dist_reg <= distance;
            ang_reg  <= angle;
            now_reg  <= now_ms;
        end
    end

    // update decider state at the same edge the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_f_reg      <= '0;
            ang_f_reg       <= '0;
            seeded_reg      <= 1'b0;
            prev_cmd_reg    <= DRIVE_STOP;
            change_time_reg <= '0;
        end
        else if (adv)
        begin
            dist_f_reg   <= dist_f_next;
            ang_f_reg    <= ang_f_next;
            seeded_reg   <= seeded_reg || sample_ok;
            prev_cmd_reg <= dec.cmd;
            if (dec.set_time)
            begin
                change_time_reg <= now_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // outputs show the integer part (floor) of the filters
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd_reg     <= dec.cmd;
            sm_dist_reg <= dist_f_next[FW-1:FILTER_FRACTION_BITS];
            sm_ang_reg  <= ang_f_next[FW-1:FILTER_FRACTION_BITS];
        end
    end

    assign out_valid         = out_vld_reg;
    assign command           = cmd_reg;
    assign smoothed_distance = sm_dist_reg;
    assign smoothed_angle    = sm_ang_reg;

`ifndef SYNTHESIS
    // an invalid distance always yields stop
    a_invalid_stop: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !sample_ok |=> cmd_reg == DRIVE_STOP)
        else $error("invalid sample did not give stop");

    // the remembered command matches the one just issued
    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> prev_cmd_reg == cmd_reg)
        else $error("previous command differs from issued command");

    // state moves only when an item advances
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(prev_cmd_reg) && $stable(change_time_reg) && $stable(dist_f_reg))
        else $error("decider state changed without an item");

    // once seeded, the filters stay seeded
    a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        seeded_reg |=> seeded_reg)
        else $error("filter seed flag cleared");
`endif

endmodule

`default_nettype wire
